// ===== src/crism_pkg.sv =====
// Package for the smoothed byte-rate meter: shared widths, lane control types,
// and the signed Q2.16 filter coefficients. No dependencies.
`default_nettype none

package crism_pkg;

    localparam int unsigned TOTAL_W   = 64;
    localparam int unsigned SCALE_W   = 32;
    localparam int unsigned RATE_W    = 40;
    localparam int unsigned HIST_TAPS = 5;
    localparam int unsigned COEF_W    = 18;
    localparam int unsigned OPND_W    = RATE_W + 2;
    localparam int unsigned PROD_W    = COEF_W + OPND_W;
    localparam int unsigned ACC_W     = 62;
    localparam int unsigned TAP_W     = 3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd64;
    localparam logic [RATE_W-1:0]  RATE_MAX    = {RATE_W{1'b1}};

    // Feed-forward gain and the feedback taps, oldest output first.
    localparam logic signed [COEF_W-1:0] COEF_B  = 18'sd31208;
    localparam logic signed [COEF_W-1:0] COEF_A0 = 18'sd3123;
    localparam logic signed [COEF_W-1:0] COEF_A1 = -18'sd10945;
    localparam logic signed [COEF_W-1:0] COEF_A2 = 18'sd21500;
    localparam logic signed [COEF_W-1:0] COEF_A3 = -18'sd30720;
    localparam logic signed [COEF_W-1:0] COEF_A4 = 18'sd19988;

    // Number of multiply-accumulate steps: the feed-forward term plus the taps.
    localparam logic [TAP_W-1:0] MAC_STEPS = TAP_W'(HIST_TAPS + 1);

    typedef struct packed {
        logic start;
        logic prime_only;
    } lane_ctrl_t;

    typedef struct packed {
        logic done;
        logic idle;
    } lane_stat_t;

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        case (tap)
            3'd0:    c = COEF_B;
            3'd1:    c = COEF_A0;
            3'd2:    c = COEF_A1;
            3'd3:    c = COEF_A2;
            3'd4:    c = COEF_A3;
            3'd5:    c = COEF_A4;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/crism_ifs.sv =====
// Valid/ready channel interfaces for the byte-rate meter: counter samples in,
// smoothed rates out. Depends on crism_pkg for the field widths.
`default_nettype none

interface crism_sample_if;
    logic                            valid;
    logic                            ready;
    logic [crism_pkg::TOTAL_W-1:0]   tx_bytes_total;
    logic [crism_pkg::TOTAL_W-1:0]   rx_bytes_total;

    modport source (output valid, output tx_bytes_total, output rx_bytes_total,
                    input ready);
    modport sink   (input valid, input tx_bytes_total, input rx_bytes_total,
                    output ready);
endinterface

interface crism_rate_if;
    logic                           valid;
    logic                           ready;
    logic [crism_pkg::RATE_W-1:0]   tx_rate;
    logic [crism_pkg::RATE_W-1:0]   rx_rate;

    modport source (output valid, output tx_rate, output rx_rate, input ready);
    modport sink   (input valid, input tx_rate, input rx_rate, output ready);
endinterface

`default_nettype wire

// ===== src/crism_lane.sv =====
// One channel of the rate meter: counter delta, scaling to a raw rate with a
// shared 32x32 multiplier, then the IIR smoother on a sequential MAC. Uses crism_pkg.
`default_nettype none

module crism_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crism_pkg::lane_ctrl_t         ctrl,
    input  logic [crism_pkg::TOTAL_W-1:0] total,
    input  logic [crism_pkg::SCALE_W-1:0] scale,
    output crism_pkg::lane_stat_t         stat,
    output logic [crism_pkg::RATE_W-1:0]  rate
);
    import crism_pkg::*;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MLO  = 6'b000010,
        L_MHI  = 6'b000100,
        L_RAW  = 6'b001000,
        L_MAC  = 6'b010000,
        L_FIN  = 6'b100000
    } lane_state_t;

    lane_state_t state_reg, state_next;

    logic [TOTAL_W-1:0]       last_total_reg;
    logic [RATE_W-1:0]        prev_reg;
    logic [RATE_W-1:0]        hist_reg [HIST_TAPS];
    logic [TAP_W-1:0]         tap_reg;
    logic                     done_reg;

    logic [TOTAL_W-1:0]       delta_reg;
    logic [2*SCALE_W-1:0]     plo_reg;
    logic [2*SCALE_W-1:0]     phi_reg;
    logic [RATE_W-1:0]        raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [RATE_W-1:0]        y_reg;

    logic [SCALE_W-1:0]       mul_a;
    logic [2*SCALE_W-1:0]     mul_res;
    logic [56:0]              raw_sum;
    logic [RATE_W-1:0]        raw_next;
    logic [RATE_W:0]          opnd;
    logic signed [OPND_W-1:0] opnd_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  rnd;
    logic [RATE_W-1:0]        y_next;

    // One multiplier serves both halves of the 64-bit delta.
    assign mul_a   = (state_reg == L_MLO) ? delta_reg[SCALE_W-1:0]
                                          : delta_reg[TOTAL_W-1:SCALE_W];
    assign mul_res = {{SCALE_W{1'b0}}, mul_a} * {{SCALE_W{1'b0}}, scale};

    // The high partial product lands at bit 24 of the Q32.8 rate.
    assign raw_sum = {17'd0, phi_reg[15:0], 24'd0} + {1'b0, plo_reg[63:8]};

    always_comb
    begin
        if (phi_reg[63:16] != '0 || raw_sum[56:40] != '0)
            raw_next = RATE_MAX;
        else
            raw_next = raw_sum[RATE_W-1:0];
    end

    // Step zero multiplies the sum of the two latest raw rates, later steps
    // walk the output history from oldest to newest.
    always_comb
    begin
        opnd = {1'b0, prev_reg} + {1'b0, raw_reg};
        for (int i = 0; i < HIST_TAPS; i++)
        begin
            if (tap_reg == TAP_W'(i + 1))
                opnd = {1'b0, hist_reg[i]};
        end
    end

    assign opnd_s    = $signed({1'b0, opnd});
    assign prod_next = tap_coef(tap_reg) * opnd_s;

    assign rnd = acc_reg + ACC_W'(32768);

    always_comb
    begin
        if (acc_reg <= 0)
            y_next = '0;
        else if (rnd[ACC_W-1:RATE_W+16] != '0)
            y_next = RATE_MAX;
        else
            y_next = rnd[RATE_W+15:16];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (ctrl.start && !ctrl.prime_only)
                    state_next = L_MLO;
            end
            L_MLO: state_next = L_MHI;
            L_MHI: state_next = L_RAW;
            L_RAW: state_next = L_MAC;
            L_MAC:
            begin
                if (tap_reg == MAC_STEPS)
                    state_next = L_FIN;
            end
            L_FIN: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= L_IDLE;
            done_reg       <= 1'b0;
            tap_reg        <= '0;
            last_total_reg <= '0;
            prev_reg       <= '0;
            for (int i = 0; i < HIST_TAPS; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == L_IDLE && ctrl.start)
            begin
                last_total_reg <= total;
                if (ctrl.prime_only)
                    done_reg <= 1'b1;
            end
            if (state_reg == L_RAW)
                tap_reg <= '0;
            else if (state_reg == L_MAC)
                tap_reg <= tap_reg + 1'b1;
            if (state_reg == L_FIN)
            begin
                done_reg <= 1'b1;
                prev_reg <= raw_reg;
                for (int i = 0; i < HIST_TAPS - 1; i++)
                    hist_reg[i] <= hist_reg[i+1];
                hist_reg[HIST_TAPS-1] <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && ctrl.start)
        begin
            delta_reg <= total - last_total_reg;
            y_reg     <= '0;
        end
        if (state_reg == L_MLO)
            plo_reg <= mul_res;
        if (state_reg == L_MHI)
            phi_reg <= mul_res;
        if (state_reg == L_RAW)
        begin
            raw_reg <= raw_next;
            acc_reg <= '0;
        end
        if (state_reg == L_MAC)
        begin
            prod_reg <= prod_next;
            if (tap_reg != '0)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == L_FIN)
            y_reg <= y_next;
    end

    assign stat.done = done_reg;
    assign stat.idle = (state_reg == L_IDLE);
    assign rate      = y_reg;

endmodule

`default_nettype wire

// ===== src/counter_rate_iir_smoother_unit.sv =====
// Top level of the smoothed byte-rate meter: two channel lanes, the scale
// register and the merged output register. Uses crism_pkg, crism_ifs, crism_lane.
//
// Usage: samples carries one pair of running byte totals per transaction
// (valid/ready, taken when both are high). rates returns one transaction per
// sample with the smoothed tx and rx rates in KiB/s, unsigned Q32.8.
// cfg_we/cfg_wdata write rate_scale (Q16.16, bytes per sample to KiB/s);
// write it only while no sample is in flight.
// The first sample after reset only records the totals; its result carries
// zero rates. Every later sample runs both lanes in lockstep: two partial
// products on each lane's own 32x32 multiplier, a saturating add, then six
// steps on the filter MAC. A new sample is taken only once both lanes are
// done and their result has moved on to the output register.
// The output register frees the lanes: a new sample is taken while a
// result waits. If the receiver stalls and the next result is ready, the
// lanes hold it and no further sample is taken until the output drains.
// Reset clears the filter state, the recorded totals and sets rate_scale to 64.
`default_nettype none

module counter_rate_iir_smoother_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crism_pkg::SCALE_W-1:0] cfg_wdata,
    crism_sample_if.sink                  samples,
    crism_rate_if.source                  rates
);
    import crism_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_HOLD = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_reg;
    logic               primed_reg;
    logic               out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]  tx_rate_reg;
    logic [RATE_W-1:0]  rx_rate_reg;

    lane_ctrl_t         lane_ctrl;
    lane_stat_t         tx_stat, rx_stat;
    logic [RATE_W-1:0]  tx_lane_rate, rx_lane_rate;

    logic               accept;
    logic               out_free;
    logic               load_out;

    assign samples.ready = (state_reg == T_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || rates.ready;

    assign lane_ctrl.start      = accept;
    assign lane_ctrl.prime_only = !primed_reg;

    crism_lane u_tx_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .total (samples.tx_bytes_total),
        .scale (scale_reg),
        .stat  (tx_stat),
        .rate  (tx_lane_rate)
    );

    crism_lane u_rx_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .total (samples.rx_bytes_total),
        .scale (scale_reg),
        .stat  (rx_stat),
        .rate  (rx_lane_rate)
    );

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                    state_next = T_RUN;
            end
            T_RUN:
            begin
                if (tx_stat.done && rx_stat.done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = T_IDLE;
                    end
                    else
                        state_next = T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (rates.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            scale_reg     <= SCALE_RESET;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                scale_reg <= cfg_wdata;
            if (accept)
                primed_reg <= 1'b1;
        end
    end

    // The lanes keep their result until the next start, so the merge can
    // pick it up late.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tx_rate_reg <= tx_lane_rate;
            rx_rate_reg <= rx_lane_rate;
        end
    end

    assign rates.valid   = out_valid_reg;
    assign rates.tx_rate = tx_rate_reg;
    assign rates.rx_rate = rx_rate_reg;

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        tx_stat.done == rx_stat.done)
        else $error("channel lanes finished in different cycles");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tx_stat.done |-> state_reg == T_RUN)
        else $error("lane finished while no transaction was running");

    a_accept_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> tx_stat.idle && rx_stat.idle)
        else $error("sample taken while a lane was busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || rates.ready)
        else $error("output register overwritten before it was taken");

    a_primed_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> primed_reg)
        else $error("first sample did not prime the filter");

endmodule

`default_nettype wire
